// ===== rtl/b64sc_pkg.sv =====
package b64sc_pkg;

	// codec modes
	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	// error codes
	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_SYMBOL = 2'd1;
	localparam logic [1:0] ERR_LENGTH = 2'd2;

	// register indexes
	localparam logic REG_CODEC_MODE = 1'b0;

	localparam logic [7:0] PAD_CHAR  = 8'h3D;
	localparam logic [5:0] SYM_PLUS  = 6'd62;
	localparam logic [5:0] SYM_SLASH = 6'd63;

	localparam int MAX_RES = 4;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic [1:0] err;
	} res_t;

	typedef struct packed {
		logic [1:0]  phase;
		logic [17:0] held;
		logic        pad;
		logic        drop;
	} state_t;

	typedef struct packed {
		state_t                nxt;
		logic [2:0]            cnt;
		res_t [MAX_RES-1:0]    res;
	} step_t;

	// sextet to alphabet character
	function automatic logic [7:0] enc_char(input logic [5:0] v);
		logic [7:0] w;
		w = {2'b00, v};
		if (v < 6'd26) begin
			return 8'd65 + w;
		end else if (v < 6'd52) begin
			return 8'd97 + w - 8'd26;
		end else if (v < SYM_PLUS) begin
			return 8'd48 + w - 8'd52;
		end else if (v == SYM_PLUS) begin
			return 8'd43;
		end else begin
			return 8'd47;
		end
	endfunction

	// character to {valid, sextet}
	function automatic logic [6:0] sym_decode(input logic [7:0] c);
		logic [7:0] d;
		d = 8'd0;
		if (c >= 8'd65 && c <= 8'd90) begin
			d = c - 8'd65;
			return {1'b1, d[5:0]};
		end else if (c >= 8'd97 && c <= 8'd122) begin
			d = c - 8'd97 + 8'd26;
			return {1'b1, d[5:0]};
		end else if (c >= 8'd48 && c <= 8'd57) begin
			d = c - 8'd48 + 8'd52;
			return {1'b1, d[5:0]};
		end else if (c == 8'd43) begin
			return {1'b1, SYM_PLUS};
		end else if (c == 8'd47) begin
			return {1'b1, SYM_SLASH};
		end else begin
			return {1'b0, d[5:0]};
		end
	endfunction

endpackage

// ===== rtl/b64sc_step.sv =====
module b64sc_step (
	input  logic                 mode,
	input  b64sc_pkg::state_t    st,
	input  logic [7:0]           in_byte,
	input  logic                 in_last,
	output b64sc_pkg::step_t     step
);

	logic [1:0]  ph;
	logic [6:0]  sv;
	logic        err_hit;
	logic [1:0]  err_val;
	logic [7:0]  b0;
	logic [7:0]  b1;
	logic [5:0]  s0;
	logic [5:0]  s1;
	logic [5:0]  s2;
	b64sc_pkg::state_t clr;

	assign ph = st.phase;
	assign sv = b64sc_pkg::sym_decode(in_byte);
	assign clr = '0;

	always_comb begin
		step = '0;
		step.nxt = st;
		err_hit = 1'b0;
		err_val = b64sc_pkg::ERR_NONE;
		b0 = 8'd0;
		b1 = 8'd0;
		s0 = st.held[17:12];
		s1 = st.held[11:6];
		s2 = st.held[5:0];
		if (st.drop) begin
			if (in_last) begin
				step.nxt = clr;
			end
		end else if (mode == b64sc_pkg::MODE_ENCODE) begin
			if (ph < 2'd2) begin
				step.nxt.held = {2'b00, st.held[7:0], in_byte};
				step.nxt.phase = 2'(ph + 2'd1);
				if (in_last) begin
					step.nxt = clr;
					step.cnt = 3'd4;
					if (ph == 2'd0) begin
						step.res[0].data = b64sc_pkg::enc_char(in_byte[7:2]);
						step.res[1].data = b64sc_pkg::enc_char({in_byte[1:0], 4'b0000});
						step.res[2].data = b64sc_pkg::PAD_CHAR;
					end else begin
						b0 = st.held[7:0];
						b1 = in_byte;
						step.res[0].data = b64sc_pkg::enc_char(b0[7:2]);
						step.res[1].data = b64sc_pkg::enc_char({b0[1:0], b1[7:4]});
						step.res[2].data = b64sc_pkg::enc_char({b1[3:0], 2'b00});
					end
					step.res[3].data = b64sc_pkg::PAD_CHAR;
					step.res[3].last = 1'b1;
				end
			end else begin
				b0 = st.held[15:8];
				b1 = st.held[7:0];
				step.nxt = clr;
				step.cnt = 3'd4;
				step.res[0].data = b64sc_pkg::enc_char(b0[7:2]);
				step.res[1].data = b64sc_pkg::enc_char({b0[1:0], b1[7:4]});
				step.res[2].data = b64sc_pkg::enc_char({b1[3:0], in_byte[7:6]});
				step.res[3].data = b64sc_pkg::enc_char(in_byte[5:0]);
				step.res[3].last = in_last;
			end
		end else begin
			b0 = {s0, s1[5:4]};
			b1 = {s1[3:0], s2[5:2]};
			if (in_last && ph != 2'd3) begin
				err_hit = 1'b1;
				err_val = b64sc_pkg::ERR_LENGTH;
			end else if (ph < 2'd2) begin
				if (!sv[6]) begin
					err_hit = 1'b1;
					err_val = b64sc_pkg::ERR_SYMBOL;
				end else begin
					step.nxt.held = {st.held[11:0], sv[5:0]};
					step.nxt.phase = 2'(ph + 2'd1);
				end
			end else if (ph == 2'd2) begin
				if (in_byte == b64sc_pkg::PAD_CHAR) begin
					step.nxt.held = {st.held[11:0], 6'd0};
					step.nxt.pad = 1'b1;
					step.nxt.phase = 2'd3;
				end else if (!sv[6]) begin
					err_hit = 1'b1;
					err_val = b64sc_pkg::ERR_SYMBOL;
				end else begin
					step.nxt.held = {st.held[11:0], sv[5:0]};
					step.nxt.pad = 1'b0;
					step.nxt.phase = 2'd3;
				end
			end else begin
				if (in_byte == b64sc_pkg::PAD_CHAR) begin
					step.nxt = clr;
					step.res[0].data = b0;
					if (st.pad) begin
						step.cnt = 3'd1;
						step.res[0].last = in_last;
					end else begin
						step.cnt = 3'd2;
						step.res[1].data = b1;
						step.res[1].last = in_last;
					end
				end else if (!sv[6] || st.pad) begin
					err_hit = 1'b1;
					err_val = b64sc_pkg::ERR_SYMBOL;
				end else begin
					step.nxt = clr;
					step.cnt = 3'd3;
					step.res[0].data = b0;
					step.res[1].data = b1;
					step.res[2].data = {s2[1:0], sv[5:0]};
					step.res[2].last = in_last;
				end
			end
		end
		// single error item, then drop the rest of the message
		if (err_hit) begin
			step.res = '0;
			step.res[0].last = 1'b1;
			step.res[0].err = err_val;
			step.cnt = 3'd1;
			step.nxt = clr;
			step.nxt.drop = !in_last;
		end
	end

endmodule

// ===== rtl/b64sc_outbuf.sv =====
module b64sc_outbuf (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  load,
	input  logic [2:0]                            load_cnt,
	input  b64sc_pkg::res_t [b64sc_pkg::MAX_RES-1:0] load_res,
	input  logic                                  out_stall,
	output logic                                  out_valid,
	output b64sc_pkg::res_t                       head,
	output logic                                  free
);

	b64sc_pkg::res_t [b64sc_pkg::MAX_RES-1:0] res_q;
	logic [2:0] cnt_q;
	logic       taken;

	assign out_valid = (cnt_q != 3'd0);
	assign taken = out_valid && !out_stall;
	// empty now, or last entry leaving at this edge
	assign free = (cnt_q == 3'd0) || (cnt_q == 3'd1 && taken);
	assign head = res_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (load) begin
			cnt_q <= load_cnt;
		end else if (taken) begin
			cnt_q <= 3'(cnt_q - 3'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= load_res;
		end else if (taken) begin
			res_q <= {b64sc_pkg::res_t'('0), res_q[b64sc_pkg::MAX_RES-1:1]};
		end
	end

endmodule

// ===== rtl/base64_stream_codec_core.sv =====
// base64 stream codec, standard alphabet with '=' padding
// input channel: in_valid/in_stall carry in_byte and in_last; in_last marks
//   the final item of a message
// output channel: out_valid/out_stall carry out_byte, out_last, error_code
// apb port: one register at byte address 0, codec_mode (0 encode, 1 decode);
//   any write to it also clears the group state; write it only when idle
// encode: three bytes give four characters, a short final group is padded
// decode: four characters give one to three bytes; a bad symbol or a short
//   message gives one error item with out_last set, and the rest of the
//   message up to in_last is dropped
// data path: an accepted item sits in the input register, its results are
//   loaded from there into the result buffer once it is free, and are taken
//   from the buffer head one per cycle while out_stall is low
// throughput: items that give no result move on every cycle; an item that
//   gives results waits until the buffer has drained, so encode is bound by
//   the single-item output port
// reset: clears mode to encode, the group state and all valid flags
// while the receiver stalls, the head item holds and the input register
//   fills, then in_stall rises
module base64_stream_codec_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        out_last,
	output logic [1:0]  error_code,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// input register
	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              last_s1;

	// group state
	logic              mode_q;
	b64sc_pkg::state_t state_q;

	b64sc_pkg::step_t  step;
	b64sc_pkg::res_t   head;
	logic              buf_free;
	logic              go_s1;
	logic              cfg_wr;

	assign pready = 1'b1;
	assign prdata = {31'd0, mode_q};
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == b64sc_pkg::REG_CODEC_MODE);

	// per-item logic
	b64sc_step u_step (
		.mode    (mode_q),
		.st      (state_q),
		.in_byte (byte_s1),
		.in_last (last_s1),
		.step    (step)
	);

	// items with no result never wait on the output side
	assign go_s1 = valid_s1 && ((step.cnt == 3'd0) || buf_free);
	assign in_stall = valid_s1 && !go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= b64sc_pkg::MODE_ENCODE;
			state_q <= '0;
		end else if (cfg_wr) begin
			mode_q  <= pwdata[0];
			state_q <= '0;
		end else if (go_s1) begin
			state_q <= step.nxt;
		end
	end

	// result buffer, drained one item per cycle while out_stall is low
	b64sc_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (go_s1 && (step.cnt != 3'd0)),
		.load_cnt  (step.cnt),
		.load_res  (step.res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.head      (head),
		.free      (buf_free)
	);

	assign out_byte   = head.data;
	assign out_last   = head.last;
	assign error_code = head.err;

endmodule
